// ===== hw/rtl/dff_pkg.sv =====
// Package for the duplicate frame filter: field widths, reset values,
// function codes and the table entry type. No dependencies.
`timescale 1ns / 1ps

package dff_pkg;

	localparam int KEY_W        = 40;
	localparam int TIME_W       = 32;
	localparam int WINDOW_W     = 16;
	localparam int ENTRIES_DEF  = 8;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd400;

	localparam logic FUNC_CHECK = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

// ===== hw/rtl/dff_table.sv =====
// Key / first-seen-time table: one synchronous memory, one write port,
// one read port with a registered read. Depends on dff_pkg.
`timescale 1ns / 1ps

module dff_table import dff_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/dff_ctrl.sv =====
// Scan sequencer: walks the table one entry a cycle, matches the key,
// checks the time window and writes back the entry. Depends on dff_pkg.
`timescale 1ns / 1ps

module dff_ctrl import dff_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic [KEY_W-1:0]    frame_key,
	input  logic [TIME_W-1:0]   rx_time,
	input  logic [WINDOW_W-1:0] window_ms,
	output logic                done,
	output logic                accept,
	output logic                hit,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  entry_t              rd_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output entry_t              wr_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	state_t              state_q;
	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       ptr_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [KEY_W-1:0]    key_q;
	logic [TIME_W-1:0]   now_q;
	logic                done_q;
	logic                accept_q;
	logic                hit_q;

	logic                take;
	logic                is_last;
	logic                match;
	logic [TIME_W-1:0]   diff;
	logic                refresh;
	logic [AW-1:0]       idx_next;
	logic [AW-1:0]       ptr_next;

	assign take     = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign is_last  = (idx_q == LAST);
	assign idx_next = is_last ? '0 : idx_q + 1'b1;
	assign ptr_next = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign match    = valid_q[idx_q] && (rd_data.key == key_q);
	assign diff     = now_q - rd_data.stamp;
	assign refresh  = diff > TIME_W'(window_ms);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '{key: key_q, stamp: now_q};
		unique case (state_q)
			ST_IDLE: begin
				rd_en   = take && (func == FUNC_CHECK);
				rd_addr = '0;
			end
			ST_SCAN: begin
				rd_en   = !match && !is_last;
				rd_addr = idx_next;
				if (match) begin
					wr_en   = refresh;
					wr_addr = idx_q;
				end else if (is_last) begin
					wr_en   = 1'b1;
					wr_addr = ptr_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			ptr_q    <= '0;
			valid_q  <= '0;
			done_q   <= 1'b0;
			accept_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (func == FUNC_CLEAR) begin
							valid_q  <= '0;
							ptr_q    <= '0;
							done_q   <= 1'b1;
							accept_q <= 1'b0;
							hit_q    <= 1'b0;
						end else begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						done_q   <= 1'b1;
						accept_q <= refresh;
						hit_q    <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (is_last) begin
						valid_q[ptr_q] <= 1'b1;
						ptr_q    <= ptr_next;
						done_q   <= 1'b1;
						accept_q <= 1'b1;
						hit_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						idx_q <= idx_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the accepted item for the scan
	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= frame_key;
			now_q <= rx_time;
		end
	end

	assign done   = done_q;
	assign accept = accept_q;
	assign hit    = hit_q;

endmodule

// ===== hw/rtl/duplicate_frame_filter_top.sv =====
// Duplicate frame filter top level: window register, scan sequencer and
// entry memory. Depends on dff_pkg, dff_table and dff_ctrl.
`timescale 1ns / 1ps

// A transfer starts when start is high and busy is low. A check item scans
// the table one entry per cycle from index 0, set by the single read port of
// the entry memory, and stops at the first valid match or after the last
// entry on a miss; the next start is taken only once the item has finished.
// A clear item empties the table without a scan. Each result is shown on
// accept and hit for one cycle with done high, the cycle after the item
// finishes; the receiver cannot stall, so it must take every done pulse.
// The window register is written with cfg_wr_en; the user must change it
// only while the block is idle, the block itself does not enforce this.

module duplicate_frame_filter_top import dff_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic [KEY_W-1:0]    frame_key,
	input  logic [TIME_W-1:0]   rx_time,
	output logic                done,
	output logic                accept,
	output logic                hit,
	input  logic                cfg_wr_en,
	input  logic [WINDOW_W-1:0] cfg_wr_data
);

	localparam int AW = $clog2(ENTRIES);

	logic [WINDOW_W-1:0] window_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	entry_t              rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	dff_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.frame_key(frame_key),
		.rx_time  (rx_time),
		.window_ms(window_q),
		.done     (done),
		.accept   (accept),
		.hit      (hit),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	dff_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

// ===== tb/testbench.sv =====
// Testbench for duplicate_frame_filter_top: directed and random telegram traffic,
// checked against a behavioral copy of the filter table held here.
// Depends on dff_pkg and the filter RTL.
`timescale 1ns / 1ps

module testbench;
	import dff_pkg::*;

	typedef struct {
		logic accept;
		logic hit;
	} verdict_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                func = FUNC_CHECK;
	logic [KEY_W-1:0]    frame_key = '0;
	logic [TIME_W-1:0]   rx_time = '0;
	logic                cfg_wr_en = 1'b0;
	logic [WINDOW_W-1:0] cfg_wr_data = '0;
	logic                busy;
	logic                done;
	logic                accept;
	logic                hit;

	logic [KEY_W-1:0]    seen_keys [ENTRIES_DEF];
	logic [TIME_W-1:0]   seen_stamps [ENTRIES_DEF];
	logic                seen_valid [ENTRIES_DEF];
	int unsigned         replace_ptr;
	logic [WINDOW_W-1:0] window_ms;

	verdict_t expected_verdicts [$];
	int       mismatches = 0;
	bit       quiet = 1'b0;

	duplicate_frame_filter_top #(.ENTRIES(ENTRIES_DEF)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.frame_key   (frame_key),
		.rx_time     (rx_time),
		.done        (done),
		.accept      (accept),
		.hit         (hit),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void empty_table();
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			seen_keys[i] = '0;
			seen_stamps[i] = '0;
			seen_valid[i] = 1'b0;
		end
		replace_ptr = 0;
	endfunction

	function automatic verdict_t filter_telegram(logic f, logic [KEY_W-1:0] k,
			logic [TIME_W-1:0] t);
		verdict_t v;
		int slot;
		logic [TIME_W-1:0] age;
		v.accept = 1'b0;
		v.hit = 1'b0;
		slot = -1;
		if (f == FUNC_CLEAR) begin
			empty_table();
			return v;
		end
		for (int i = ENTRIES_DEF - 1; i >= 0; i--)
			if (seen_valid[i] && seen_keys[i] == k)
				slot = i;
		if (slot < 0) begin
			seen_keys[replace_ptr] = k;
			seen_stamps[replace_ptr] = t;
			seen_valid[replace_ptr] = 1'b1;
			replace_ptr = (replace_ptr + 1) % ENTRIES_DEF;
			v.accept = 1'b1;
			return v;
		end
		v.hit = 1'b1;
		age = t - seen_stamps[slot];
		if (age > TIME_W'(window_ms)) begin
			seen_stamps[slot] = t;
			v.accept = 1'b1;
		end
		return v;
	endfunction

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending: accept=%b hit=%b",
						$time, accept, hit);
			end else begin
				want = expected_verdicts.pop_front();
				if (accept !== want.accept || hit !== want.hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch: expected accept=%b hit=%b, got accept=%b hit=%b",
							$time, want.accept, want.hit, accept, hit);
				end
			end
		end
	end

	task automatic send_item(logic f, logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		frame_key <= k;
		rx_time <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_verdicts.push_back(filter_telegram(f, k, t));
	endtask

	task automatic check_frame(logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
		send_item(FUNC_CHECK, k, t);
	endtask

	task automatic clear_frames();
		send_item(FUNC_CLEAR, KEY_W'({$urandom, $urandom}), $urandom);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (ENTRIES_DEF + 4) @(posedge clk);
	endtask

	task automatic write_window(logic [WINDOW_W-1:0] w);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_ms = w;
		@(posedge clk);
	endtask

	task automatic test_table_basics();
		logic [KEY_W-1:0] ones;
		ones = '1;
		check_frame('0, 32'd0);
		check_frame('0, 32'd400);
		check_frame('0, 32'd401);
		check_frame(ones, 32'hFFFF_FFF0);
		check_frame(ones, 32'h0000_0100);
		for (int i = 0; i < 7; i++)
			check_frame(KEY_W'(1) << (i * 6), 32'h8000_0000 + i);
		check_frame(ones, 32'hFFFF_FFFF);
		check_frame('0, 32'd402);
		check_frame(KEY_W'(1) << 36, 32'h8000_0100);
		send_item(FUNC_CLEAR, ones, 32'hFFFF_FFFF);
		check_frame(ones, 32'h0000_0100);
	endtask

	task automatic test_window_extremes();
		logic [KEY_W-1:0] k;
		logic [TIME_W-1:0] t;
		k = KEY_W'({$urandom, $urandom});
		t = $urandom;
		write_window('0);
		check_frame(k, t);
		check_frame(k, t);
		check_frame(k, t + 1);
		write_window('1);
		check_frame(k, t + 1 + 32'd65535);
		check_frame(k, t + 1 + 32'd65536);
	endtask

	task automatic random_phase(int count, logic [WINDOW_W-1:0] w);
		logic [KEY_W-1:0] pool [12];
		logic [TIME_W-1:0] now;
		int unsigned roll;
		int unsigned span;
		write_window(w);
		for (int i = 0; i < 12; i++)
			pool[i] = KEY_W'({$urandom, $urandom});
		now = $urandom;
		span = 2 * w + 2;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				clear_frames();
			else if (roll < 10)
				check_frame(KEY_W'({$urandom, $urandom}), $urandom);
			else begin
				roll = $urandom_range(0, 19);
				if (roll == 0)
					now = $urandom;
				else if (roll == 1)
					now = now + w;
				else if (roll == 2)
					now = now + w + 1;
				else
					now = now + $urandom_range(0, span / 6);
				check_frame(pool[$urandom_range(0, 11)], now);
			end
		end
	endtask

	task automatic test_random_traffic();
		random_phase(150, 16'd400);
		random_phase(150, 16'd1);
		quiet = 1'b1;
		random_phase(150, 16'd65535);
		quiet = 1'b0;
		random_phase(150, 16'($urandom));
		random_phase(150, 16'($urandom_range(0, 2000)));
	endtask

	initial begin
		empty_table();
		window_ms = WINDOW_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_table_basics();
		test_window_extremes();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
